// ===== sv/ccd_pkg.sv =====
// ccd_pkg: shared constants, trig tables and controller/datapath command types
// for the cyclic coordinate descent solver.
// No dependencies.
package ccd_pkg;

	localparam int JOINT_COUNT_DEF  = 8;
	localparam int CORDIC_STEPS_DEF = 16;

	// angle width of the trig unit, q30 radians
	localparam int Z_W = 36;
	// width of cos / sin results, q30
	localparam int C_W = 32;

	localparam logic signed [Z_W-1:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [Z_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
	localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [Z_W-1:0] GAIN_Q30    = 36'sd652032874;

	localparam logic signed [15:0] ANG_PI_Q13 = 16'sd25736;

	localparam logic [1:0] F_LOAD  = 2'd0;
	localparam logic [1:0] F_ITER  = 2'd1;
	localparam logic [1:0] F_SOLVE = 2'd2;

	localparam logic [1:0] CFG_BASE_X    = 2'd0;
	localparam logic [1:0] CFG_BASE_Y    = 2'd1;
	localparam logic [1:0] CFG_THRESHOLD = 2'd2;
	localparam logic [1:0] CFG_MAX_ITER  = 2'd3;

	localparam logic [30:0] ATAN_TAB [24] = '{
		31'h3243F6A8, 31'h1DAC6705, 31'h0FADBAFC, 31'h07F56EA6, 31'h03FEAB76, 31'h01FFD55B,
		31'h00FFFAAA, 31'h007FFF55, 31'h003FFFEA, 31'h001FFFFD, 31'h000FFFFF, 31'h0007FFFF,
		31'h0003FFFF, 31'h0001FFFF, 31'h0000FFFF, 31'h00007FFF, 31'h00003FFF, 31'h00001FFF,
		31'h00000FFF, 31'h000007FF, 31'h000003FF, 31'h000001FF, 31'h000000FF, 31'h0000007F
	};

	function automatic logic signed [Z_W-1:0] atan_at(input logic [4:0] idx);
		logic signed [Z_W-1:0] v;
		v = '0;
		if (idx < 5'd24) begin
			v = $signed({5'b0, ATAN_TAB[idx]});
		end
		return v;
	endfunction

	typedef struct packed {
		logic accept;
		logic fwd_init;
		logic fwd_ang;
		logic cap_pivot;
		logic rot_go;
		logic mul;
		logic acc;
		logic dir1_go;
		logic dir2_go;
		logic save_z1;
		logic upd;
		logic test_sq;
		logic test_cmp;
	} ccd_cmd_t;

	typedef struct packed {
		logic       cdone;
		logic       conv;
		logic [9:0] max_iter;
	} ccd_sts_t;

endpackage

// ===== sv/ccd_cordic.sv =====
// ccd_cordic: shared iterative cordic, rotation mode (cos/sin of a joint angle sum)
// and vectoring mode (direction of a difference vector), one step per cycle.
// Depends on ccd_pkg.
module ccd_cordic import ccd_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
	parameter int CUM_W        = 20,
	parameter int V_W          = 27
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    rot_go,
	input  logic                    vec_go,
	input  logic signed [CUM_W-1:0] cum,
	input  logic signed [V_W-1:0]   vx,
	input  logic signed [V_W-1:0]   vy,
	output logic                    done,
	output logic signed [C_W-1:0]   cos_res,
	output logic signed [C_W-1:0]   sin_res,
	output logic signed [Z_W-1:0]   ang_res
);

	localparam int M_W       = CUM_W + 18;
	localparam int RED_STEPS = CUM_W - 16;
	localparam int RK_W      = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
	localparam int XY_W      = V_W + 19;
	localparam int SC_W      = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	typedef enum logic [1:0] {C_IDLE, C_RED, C_FOLD, C_RUN} cst_t;

	cst_t                   cst_q;
	logic                   done_q;
	logic                   rot_q;
	logic                   flip_q;
	logic                   neg_q;
	logic [M_W-1:0]         m_q;
	logic [RK_W-1:0]        rk_q;
	logic [SC_W-1:0]        st_q;
	logic signed [XY_W-1:0] x_q;
	logic signed [XY_W-1:0] y_q;
	logic signed [Z_W-1:0]  z_q;

	logic signed [M_W-1:0]  a_full;
	logic [M_W-1:0]         a_abs;
	logic [M_W-1:0]         red_sub;
	logic signed [Z_W-1:0]  rr_pos, rr, r1, r2, zf;
	logic                   ff;
	logic signed [XY_W-1:0] vxs, vys, xsh, ysh;
	logic                   ccw;
	logic signed [Z_W-1:0]  at;

	always_comb begin
		a_full  = M_W'($signed({cum, 17'b0}));
		a_abs   = a_full[M_W-1] ? M_W'(-a_full) : M_W'(a_full);
		red_sub = M_W'(TWO_PI_Q30) << rk_q;
		// after reduction the magnitude is below two pi
		rr_pos  = $signed(Z_W'(m_q));
		rr      = neg_q ? -rr_pos : rr_pos;
		r1      = (rr > PI_Q30) ? rr - TWO_PI_Q30 : rr;
		r2      = (r1 < -PI_Q30) ? r1 + TWO_PI_Q30 : r1;
		// fold into the right half plane, flip the result sign
		if (r2 > HALF_PI_Q30) begin
			zf = r2 - PI_Q30;
			ff = 1'b1;
		end else if (r2 < -HALF_PI_Q30) begin
			zf = r2 + PI_Q30;
			ff = 1'b1;
		end else begin
			zf = r2;
			ff = 1'b0;
		end
		vxs = XY_W'(vx) <<< 16;
		vys = XY_W'(vy) <<< 16;
		xsh = x_q >>> st_q;
		ysh = y_q >>> st_q;
		ccw = rot_q ? !z_q[Z_W-1] : y_q[XY_W-1];
		at  = atan_at(5'(st_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cst_q  <= C_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (cst_q)
				C_IDLE: begin
					if (rot_go) begin
						m_q   <= a_abs;
						neg_q <= a_full[M_W-1];
						rk_q  <= RK_W'(RED_STEPS - 1);
						rot_q <= 1'b1;
						cst_q <= C_RED;
					end else if (vec_go) begin
						rot_q <= 1'b0;
						st_q  <= '0;
						if (vx == '0 && vy == '0) begin
							// zero vector points +y
							z_q    <= HALF_PI_Q30;
							done_q <= 1'b1;
						end else if (vx < 0) begin
							if (vy >= 0) begin
								x_q <= vys;
								y_q <= -vxs;
								z_q <= HALF_PI_Q30;
							end else begin
								x_q <= -vys;
								y_q <= vxs;
								z_q <= -HALF_PI_Q30;
							end
							cst_q <= C_RUN;
						end else begin
							x_q   <= vxs;
							y_q   <= vys;
							z_q   <= '0;
							cst_q <= C_RUN;
						end
					end
				end
				C_RED: begin
					// restoring reduction by two pi times a power of two
					if (m_q >= red_sub) begin
						m_q <= m_q - red_sub;
					end
					if (rk_q == '0) begin
						cst_q <= C_FOLD;
					end else begin
						rk_q <= rk_q - 1'b1;
					end
				end
				C_FOLD: begin
					z_q    <= zf;
					flip_q <= ff;
					x_q    <= XY_W'(GAIN_Q30);
					y_q    <= '0;
					st_q   <= '0;
					cst_q  <= C_RUN;
				end
				C_RUN: begin
					if (ccw) begin
						x_q <= x_q - ysh;
						y_q <= y_q + xsh;
						z_q <= z_q - at;
					end else begin
						x_q <= x_q + ysh;
						y_q <= y_q - xsh;
						z_q <= z_q + at;
					end
					if (st_q == SC_W'(CORDIC_STEPS - 1)) begin
						cst_q  <= C_IDLE;
						done_q <= 1'b1;
					end else begin
						st_q <= st_q + 1'b1;
					end
				end
				default: cst_q <= C_IDLE;
			endcase
		end
	end

	assign done    = done_q;
	assign cos_res = flip_q ? C_W'(-x_q) : C_W'(x_q);
	assign sin_res = flip_q ? C_W'(-y_q) : C_W'(y_q);
	assign ang_res = z_q;

endmodule

// ===== sv/ccd_dp.sv =====
// ccd_dp: solver datapath: configuration and joint registers, forward pass
// accumulation, joint update with limit clamp, distance test.
// Depends on ccd_pkg and ccd_cordic.
module ccd_dp import ccd_pkg::*; #(
	parameter int JOINT_COUNT  = JOINT_COUNT_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
	parameter int IDX_W        = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ccd_cmd_t            cmd,
	input  logic [IDX_W-1:0]    rd_idx,
	output ccd_sts_t            sts,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_addr,
	input  logic [19:0]         cfg_wdata,
	input  logic [1:0]          func,
	input  logic [2:0]          joint_index,
	input  logic [17:0]         bone_length,
	input  logic signed [15:0]  limit_low,
	input  logic signed [15:0]  limit_high,
	input  logic signed [15:0]  start_angle,
	input  logic signed [19:0]  target_x,
	input  logic signed [19:0]  target_y,
	output logic signed [19:0]  end_x,
	output logic signed [19:0]  end_y,
	output logic                converged
);

	localparam int CUM_W = 17 + $clog2(JOINT_COUNT);
	localparam int POS_W = 22 + $clog2(JOINT_COUNT + 1);
	localparam int V_W   = POS_W + 1;
	localparam int PR_W  = 19 + C_W;
	localparam int SQ_W  = 2 * V_W;
	localparam int D_W   = Z_W + 1;
	localparam int A_W   = 21;
	localparam logic signed [PR_W-1:0] RND_Q30 = PR_W'(2**29);

	logic signed [19:0]      base_x_q, base_y_q;
	logic [15:0]             thr_q;
	logic [9:0]              maxit_q;
	logic signed [15:0]      ang_q [JOINT_COUNT];
	logic [17:0]             len_q [JOINT_COUNT];
	logic signed [15:0]      min_q [JOINT_COUNT];
	logic signed [15:0]      max_q [JOINT_COUNT];

	logic signed [19:0]      tx_q, ty_q;
	logic signed [CUM_W-1:0] cum_q;
	logic signed [POS_W-1:0] px_q, py_q, pivx_q, pivy_q;
	logic signed [PR_W-1:0]  prodx_q, prody_q;
	logic signed [Z_W-1:0]   z1_q;
	logic [SQ_W-1:0]         sqx_q, sqy_q;
	logic                    conv_q;

	logic signed [15:0]      rd_ang, rd_min, rd_max;
	logic [17:0]             rd_len;
	logic                    cdone;
	logic signed [C_W-1:0]   cos_res, sin_res;
	logic signed [Z_W-1:0]   ang_res;
	logic signed [V_W-1:0]   tgt_dx, tgt_dy, end_dx, end_dy, vx, vy, ex, ey;
	logic signed [PR_W-1:0]  bx, by;
	logic signed [D_W-1:0]   d0, d1, d2, dsh;
	logic signed [A_W-1:0]   a_new, a_hi, a_cl;
	logic [31:0]             thr_sq;
	logic [SQ_W:0]           dist_sq;
	logic                    load_wr;

	assign rd_ang = ang_q[rd_idx];
	assign rd_len = len_q[rd_idx];
	assign rd_min = min_q[rd_idx];
	assign rd_max = max_q[rd_idx];

	always_comb begin
		tgt_dx = V_W'(tx_q) - V_W'(pivx_q);
		tgt_dy = V_W'(ty_q) - V_W'(pivy_q);
		end_dx = V_W'(px_q) - V_W'(pivx_q);
		end_dy = V_W'(py_q) - V_W'(pivy_q);
		vx     = cmd.dir2_go ? end_dx : tgt_dx;
		vy     = cmd.dir2_go ? end_dy : tgt_dy;
		ex     = V_W'(px_q) - V_W'(tx_q);
		ey     = V_W'(py_q) - V_W'(ty_q);
		bx     = (prodx_q + RND_Q30) >>> 30;
		by     = (prody_q + RND_Q30) >>> 30;
		// joint turn: target direction minus end direction, wrapped
		d0     = D_W'(z1_q) - D_W'(ang_res);
		d1     = (d0 > D_W'(PI_Q30)) ? d0 - D_W'(TWO_PI_Q30) : d0;
		d2     = (d1 < -D_W'(PI_Q30)) ? d1 + D_W'(TWO_PI_Q30) : d1;
		dsh    = (d2 + D_W'(65536)) >>> 17;
		a_new  = A_W'(rd_ang) + A_W'(dsh);
		// crossed limits end on the low limit
		a_hi   = (a_new > A_W'(rd_max)) ? A_W'(rd_max) : a_new;
		a_cl   = (a_hi < A_W'(rd_min)) ? A_W'(rd_min) : a_hi;
		thr_sq  = thr_q * thr_q;
		dist_sq = {1'b0, sqx_q} + {1'b0, sqy_q};
		load_wr = cmd.accept && func == F_LOAD && int'(joint_index) < JOINT_COUNT;
	end

	ccd_cordic #(
		.CORDIC_STEPS (CORDIC_STEPS),
		.CUM_W        (CUM_W),
		.V_W          (V_W)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.rot_go  (cmd.rot_go),
		.vec_go  (cmd.dir1_go | cmd.dir2_go),
		.cum     (cum_q),
		.vx      (vx),
		.vy      (vy),
		.done    (cdone),
		.cos_res (cos_res),
		.sin_res (sin_res),
		.ang_res (ang_res)
	);

	// configuration and joint tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_x_q <= '0;
			base_y_q <= '0;
			thr_q    <= 16'd256;
			maxit_q  <= 10'd100;
			for (int n = 0; n < JOINT_COUNT; n++) begin
				ang_q[n] <= '0;
				len_q[n] <= '0;
				min_q[n] <= -ANG_PI_Q13;
				max_q[n] <= ANG_PI_Q13;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					CFG_BASE_X:    base_x_q <= cfg_wdata;
					CFG_BASE_Y:    base_y_q <= cfg_wdata;
					CFG_THRESHOLD: thr_q    <= cfg_wdata[15:0];
					CFG_MAX_ITER:  maxit_q  <= cfg_wdata[9:0];
					default: ;
				endcase
			end
			if (load_wr) begin
				len_q[IDX_W'(joint_index)] <= bone_length;
				min_q[IDX_W'(joint_index)] <= limit_low;
				max_q[IDX_W'(joint_index)] <= limit_high;
				ang_q[IDX_W'(joint_index)] <= start_angle;
			end else if (cmd.upd) begin
				ang_q[rd_idx] <= a_cl[15:0];
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			tx_q <= target_x;
			ty_q <= target_y;
		end
		if (cmd.fwd_init) begin
			px_q  <= POS_W'(base_x_q);
			py_q  <= POS_W'(base_y_q);
			cum_q <= '0;
		end
		if (cmd.fwd_ang) begin
			cum_q <= cum_q + CUM_W'(rd_ang);
			if (cmd.cap_pivot) begin
				pivx_q <= px_q;
				pivy_q <= py_q;
			end
		end
		if (cmd.mul) begin
			prodx_q <= $signed({1'b0, rd_len}) * cos_res;
			prody_q <= $signed({1'b0, rd_len}) * sin_res;
		end
		if (cmd.acc) begin
			px_q <= px_q + POS_W'(bx);
			py_q <= py_q + POS_W'(by);
		end
		if (cmd.save_z1) begin
			z1_q <= ang_res;
		end
		if (cmd.test_sq) begin
			sqx_q <= SQ_W'(ex * ex);
			sqy_q <= SQ_W'(ey * ey);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_q <= 1'b0;
		end else if (cmd.test_cmp) begin
			conv_q <= dist_sq < (SQ_W+1)'(thr_sq);
		end
	end

	always_comb begin
		if (px_q > POS_W'(20'sh7FFFF)) begin
			end_x = 20'sh7FFFF;
		end else if (px_q < POS_W'(20'sh80000)) begin
			end_x = 20'sh80000;
		end else begin
			end_x = px_q[19:0];
		end
		if (py_q > POS_W'(20'sh7FFFF)) begin
			end_y = 20'sh7FFFF;
		end else if (py_q < POS_W'(20'sh80000)) begin
			end_y = 20'sh80000;
		end else begin
			end_y = py_q[19:0];
		end
	end

	assign converged    = conv_q;
	assign sts.cdone    = cdone;
	assign sts.conv     = conv_q;
	assign sts.max_iter = maxit_q;

endmodule

// ===== sv/ccd_ctrl.sv =====
// ccd_ctrl: solver sequencer: forward passes, per-joint turn steps, distance
// tests and the iteration count of a word.
// Depends on ccd_pkg.
module ccd_ctrl import ccd_pkg::*; #(
	parameter int JOINT_COUNT = JOINT_COUNT_DEF,
	parameter int IDX_W       = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       func,
	input  ccd_sts_t         sts,
	output logic             busy,
	output logic             done,
	output logic [9:0]       iterations_used,
	output ccd_cmd_t         cmd,
	output logic [IDX_W-1:0] rd_idx
);

	localparam logic [IDX_W-1:0] LAST = IDX_W'(JOINT_COUNT - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_FINIT, S_FANG, S_FROT, S_FRWT, S_FMUL, S_FACC,
		S_D1, S_D1WT, S_D2, S_D2WT, S_UPD, S_TSQ, S_TCMP, S_TDEC
	} state_t;

	state_t           state_q;
	logic             done_q;
	logic             in_iter_q;
	logic [IDX_W-1:0] j_q, i_q;
	logic [9:0]       k_q, cap_q;

	always_comb begin
		cmd           = '0;
		cmd.accept    = start && state_q == S_IDLE;
		cmd.fwd_init  = state_q == S_FINIT;
		cmd.fwd_ang   = state_q == S_FANG;
		cmd.cap_pivot = in_iter_q && j_q == i_q;
		cmd.rot_go    = state_q == S_FROT;
		cmd.mul       = state_q == S_FMUL;
		cmd.acc       = state_q == S_FACC;
		cmd.dir1_go   = state_q == S_D1;
		cmd.save_z1   = state_q == S_D1WT && sts.cdone;
		cmd.dir2_go   = state_q == S_D2;
		cmd.upd       = state_q == S_UPD;
		cmd.test_sq   = state_q == S_TSQ;
		cmd.test_cmp  = state_q == S_TCMP;
		rd_idx        = (state_q == S_UPD) ? i_q : j_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			done_q    <= 1'b0;
			in_iter_q <= 1'b0;
			j_q       <= '0;
			i_q       <= '0;
			k_q       <= '0;
			cap_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						k_q       <= '0;
						in_iter_q <= 1'b0;
						// an iterate word is a solve capped at one
						case (func)
							F_SOLVE: cap_q <= sts.max_iter;
							F_ITER:  cap_q <= 10'd1;
							default: cap_q <= 10'd0;
						endcase
						state_q <= S_FINIT;
					end
				end
				S_FINIT: begin
					j_q     <= '0;
					state_q <= S_FANG;
				end
				S_FANG: state_q <= S_FROT;
				S_FROT: state_q <= S_FRWT;
				S_FRWT: begin
					if (sts.cdone) begin
						state_q <= S_FMUL;
					end
				end
				S_FMUL: state_q <= S_FACC;
				S_FACC: begin
					if (j_q == LAST) begin
						state_q <= in_iter_q ? S_D1 : S_TSQ;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_FANG;
					end
				end
				S_D1: state_q <= S_D1WT;
				S_D1WT: begin
					if (sts.cdone) begin
						state_q <= S_D2;
					end
				end
				S_D2: state_q <= S_D2WT;
				S_D2WT: begin
					if (sts.cdone) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (i_q == '0) begin
						in_iter_q <= 1'b0;
					end else begin
						i_q <= i_q - 1'b1;
					end
					state_q <= S_FINIT;
				end
				S_TSQ:  state_q <= S_TCMP;
				S_TCMP: state_q <= S_TDEC;
				S_TDEC: begin
					// the test before the first iteration never stops a solve
					if (k_q == cap_q || (k_q != '0 && sts.conv)) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						in_iter_q <= 1'b1;
						i_q       <= LAST;
						k_q       <= k_q + 1'b1;
						state_q   <= S_FINIT;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy            = state_q != S_IDLE;
	assign done            = done_q;
	assign iterations_used = k_q;

endmodule

// ===== sv/ccd_inverse_kinematics.sv =====
// ccd_inverse_kinematics: top level of the planar cyclic coordinate descent solver.
// Depends on ccd_pkg, ccd_ctrl and ccd_dp.
//
// Usage:
//   A word is taken at a rising edge with start high and busy low. func selects
//   load joint, one iteration, or a full solve; targets ride along with every word.
//   Each word gives one result on end_x, end_y, converged and iterations_used,
//   valid for the single cycle in which done is high; the receiver cannot stall
//   it and it is never repeated. busy falls in that same cycle, so the next
//   word can be taken at the edge that ends it.
//   Registers must be written through cfg_we / cfg_addr / cfg_wdata only while
//   busy is low; the block itself does not enforce it.
// Sequence: a forward pass runs each of the N = JOINT_COUNT joints through the
//   shared cordic (R = clog2(N) + 1 reduction steps); a load or unused word is
//   a pass and a test. An iteration is, per joint, a pass, two vectoring runs and
//   an update, then a pass and a test; a solve is a pass, a test and iterations.
// Reset: asynchronous, active low; joint angles and lengths clear, limits go to
//   minus and plus pi, base 0, threshold 256, max_iter 100, no result pending.
module ccd_inverse_kinematics import ccd_pkg::*; #(
	parameter int JOINT_COUNT  = JOINT_COUNT_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	input  logic [1:0]         func,
	input  logic [2:0]         joint_index,
	input  logic [17:0]        bone_length,
	input  logic signed [15:0] limit_low,
	input  logic signed [15:0] limit_high,
	input  logic signed [15:0] start_angle,
	input  logic signed [19:0] target_x,
	input  logic signed [19:0] target_y,
	output logic signed [19:0] end_x,
	output logic signed [19:0] end_y,
	output logic               converged,
	output logic [9:0]         iterations_used,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_addr,
	input  logic [19:0]        cfg_wdata
);

	localparam int IDX_W = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

	ccd_cmd_t         cmd;
	ccd_sts_t         sts;
	logic [IDX_W-1:0] rd_idx;

	ccd_ctrl #(
		.JOINT_COUNT (JOINT_COUNT),
		.IDX_W       (IDX_W)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.func            (func),
		.sts             (sts),
		.busy            (busy),
		.done            (done),
		.iterations_used (iterations_used),
		.cmd             (cmd),
		.rd_idx          (rd_idx)
	);

	ccd_dp #(
		.JOINT_COUNT  (JOINT_COUNT),
		.CORDIC_STEPS (CORDIC_STEPS),
		.IDX_W        (IDX_W)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.rd_idx      (rd_idx),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.func        (func),
		.joint_index (joint_index),
		.bone_length (bone_length),
		.limit_low   (limit_low),
		.limit_high  (limit_high),
		.start_angle (start_angle),
		.target_x    (target_x),
		.target_y    (target_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.converged   (converged)
	);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted word did not start work");

	a_cordic_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sts.cdone |-> busy)
		else $error("cordic finished while controller idle");

endmodule

// ===== sim/tb_top.sv =====
// tb_top: self-checking testbench for the planar cyclic coordinate descent solver.
// Depends on ccd_pkg and ccd_inverse_kinematics; carries its own fixed point model of
// the chain (cordic trig, forward pass, ccd turns, limit clamp) to predict each result.
module tb_top import ccd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     JOINTS    = 8;
	localparam int     STEPS     = 16;
	localparam longint PI30      = 64'sd3373259426;
	localparam longint HALF_PI30 = 64'sd1686629713;
	localparam longint TWO_PI30  = 64'sd6746518852;
	localparam longint GAIN30    = 64'sd652032874;
	localparam logic [1:0] F_UNUSED = 2'd3;
	localparam int     CYCLE_LIMIT = 6000000;

	typedef struct {
		logic [1:0]         fn;
		logic [2:0]         jidx;
		logic [17:0]        blen;
		logic signed [15:0] lo;
		logic signed [15:0] hi;
		logic signed [15:0] ang;
		logic signed [19:0] tx;
		logic signed [19:0] ty;
	} word_t;

	typedef struct {
		logic signed [19:0] ex;
		logic signed [19:0] ey;
		logic               conv;
		logic [9:0]         used;
	} pose_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done;
	logic [1:0] func = '0;
	logic [2:0] joint_index = '0;
	logic [17:0] bone_length = '0;
	logic signed [15:0] limit_low = '0, limit_high = '0, start_angle = '0;
	logic signed [19:0] target_x = '0, target_y = '0;
	logic signed [19:0] end_x, end_y;
	logic converged;
	logic [9:0] iterations_used;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_addr = '0;
	logic [19:0] cfg_wdata = '0;

	ccd_inverse_kinematics dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.func(func), .joint_index(joint_index), .bone_length(bone_length),
		.limit_low(limit_low), .limit_high(limit_high), .start_angle(start_angle),
		.target_x(target_x), .target_y(target_y), .end_x(end_x), .end_y(end_y),
		.converged(converged), .iterations_used(iterations_used),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// chain mirror
	longint base_xm, base_ym, thresh_m, cap_m;
	int ang_q13 [JOINTS];
	int len_q8 [JOINTS];
	int min_q13 [JOINTS];
	int max_q13 [JOINTS];
	longint px [JOINTS+1];
	longint py [JOINTS+1];

	word_t word_q [$];
	pose_t pose_q [$];
	word_t cur;
	int gap = 0;
	bit no_gaps = 0;
	bit taken = 0;
	int mismatches = 0;
	int cycles = 0;

	function automatic void rotate_unit(input longint a_in, output longint c,
		output longint s);
		longint a, x, y, nx;
		bit flip;
		a = a_in % TWO_PI30;
		x = GAIN30;
		y = 0;
		flip = 0;
		if (a > PI30) a -= TWO_PI30;
		if (a < -PI30) a += TWO_PI30;
		if (a > HALF_PI30) begin
			a -= PI30;
			flip = 1;
		end else if (a < -HALF_PI30) begin
			a += PI30;
			flip = 1;
		end
		for (int i = 0; i < STEPS; i++) begin
			if (a >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				a -= longint'(ATAN_TAB[i]);
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				a += longint'(ATAN_TAB[i]);
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic longint heading(input longint dx, input longint dy);
		longint x, y, z, nx, t;
		if (dx == 0 && dy == 0) return HALF_PI30;  // zero vector points +y
		x = dx * 65536;
		y = dy * 65536;
		z = 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = HALF_PI30;
			end else begin
				t = x; x = -y; y = t; z = -HALF_PI30;
			end
		end
		for (int i = 0; i < STEPS; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += longint'(ATAN_TAB[i]);
			end else begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= longint'(ATAN_TAB[i]);
			end
			x = nx;
		end
		return z;
	endfunction

	function automatic void chain_pos();
		int cum;
		longint c, s;
		cum = 0;
		px[0] = base_xm;
		py[0] = base_ym;
		for (int i = 0; i < JOINTS; i++) begin
			cum += ang_q13[i];
			rotate_unit(longint'(cum) * 131072, c, s);
			px[i+1] = px[i] + ((longint'(len_q8[i]) * c + (64'sd1 <<< 29)) >>> 30);
			py[i+1] = py[i] + ((longint'(len_q8[i]) * s + (64'sd1 <<< 29)) >>> 30);
		end
	endfunction

	function automatic bit end_close(input longint tx, input longint ty);
		longint dx, dy;
		chain_pos();
		dx = px[JOINTS] - tx;
		dy = py[JOINTS] - ty;
		return dx * dx + dy * dy < thresh_m * thresh_m;
	endfunction

	function automatic bit ccd_pass(input longint tx, input longint ty);
		longint d;
		int a;
		for (int i = JOINTS - 1; i >= 0; i--) begin
			chain_pos();
			d = heading(tx - px[i], ty - py[i])
				- heading(px[JOINTS] - px[i], py[JOINTS] - py[i]);
			if (d > PI30) d -= TWO_PI30;
			if (d < -PI30) d += TWO_PI30;
			a = ang_q13[i] + int'((d + 65536) >>> 17);
			if (a > max_q13[i]) a = max_q13[i];
			// crossed limits end at the lower one
			if (a < min_q13[i]) a = min_q13[i];
			ang_q13[i] = a;
		end
		return end_close(tx, ty);
	endfunction

	function automatic logic [19:0] sat20(input longint v);
		if (v > 524287) v = 524287;
		if (v < -524288) v = -524288;
		return v[19:0];
	endfunction

	function automatic pose_t predict_pose(input word_t w);
		pose_t p;
		bit conv;
		longint tx, ty;
		int used;
		tx = longint'(w.tx);
		ty = longint'(w.ty);
		used = 0;
		if (w.fn == F_LOAD) begin
			len_q8[w.jidx] = int'(w.blen);
			min_q13[w.jidx] = int'(w.lo);
			max_q13[w.jidx] = int'(w.hi);
			ang_q13[w.jidx] = int'(w.ang);
		end
		if (w.fn == F_ITER) begin
			conv = ccd_pass(tx, ty);
			used = 1;
		end else if (w.fn == F_SOLVE) begin
			conv = end_close(tx, ty);
			used = int'(cap_m);
			for (int k = 0; k < cap_m; k++) begin
				conv = ccd_pass(tx, ty);
				if (conv) begin
					used = k + 1;
					break;
				end
			end
		end else begin
			conv = end_close(tx, ty);
		end
		chain_pos();
		p.ex = sat20(px[JOINTS]);
		p.ey = sat20(py[JOINTS]);
		p.conv = conv;
		p.used = used[9:0];
		return p;
	endfunction

	// word acceptance and result check share one block so the check sees the
	// queue as it stood before this edge
	always @(posedge clk) begin
		pose_t exp_p;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL ccd_inverse_kinematics");
			$finish;
		end
		if (done) begin
			if (pose_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
			end else begin
				exp_p = pose_q.pop_front();
				if (exp_p.ex !== end_x || exp_p.ey !== end_y || exp_p.conv !== converged
					|| exp_p.used !== iterations_used) begin
					mismatches++;
					if (mismatches <= 10)
						$display("exp x %0d y %0d c %0d it %0d, got x %0d y %0d c %0d it %0d",
							exp_p.ex, exp_p.ey, exp_p.conv, exp_p.used,
							end_x, end_y, converged, iterations_used);
				end
			end
		end
		if (arst_n && start && !busy) begin
			pose_q.insert(pose_q.size(), predict_pose(cur));
			void'(word_q.pop_front());
			gap = no_gaps ? 0 : $urandom_range(0, 4);
			taken = 1;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !taken) begin
				// word still waiting to be taken
			end else begin
				taken = 0;
				if (gap > 0) begin
					start <= 1'b0;
					gap--;
				end else if (word_q.size() > 0) begin
					cur = word_q[0];
					func <= cur.fn;
					joint_index <= cur.jidx;
					bone_length <= cur.blen;
					limit_low <= cur.lo;
					limit_high <= cur.hi;
					start_angle <= cur.ang;
					target_x <= cur.tx;
					target_y <= cur.ty;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	task automatic add_word(input logic [1:0] fn, input int j, input int blen, input int lo,
		input int hi, input int ang, input longint tx, input longint ty);
		word_t w;
		w.fn = fn;
		w.jidx = j[2:0];
		w.blen = blen[17:0];
		w.lo = lo[15:0];
		w.hi = hi[15:0];
		w.ang = ang[15:0];
		w.tx = sat20(tx);
		w.ty = sat20(ty);
		word_q.insert(word_q.size(), w);
	endtask

	task automatic wait_idle();
		do @(negedge clk); while (word_q.size() != 0 || pose_q.size() != 0 || start);
	endtask

	task automatic write_reg(input logic [1:0] idx, input longint val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val[19:0];
		case (idx)
			CFG_BASE_X:    base_xm = longint'($signed(val[19:0]));
			CFG_BASE_Y:    base_ym = longint'($signed(val[19:0]));
			CFG_THRESHOLD: thresh_m = longint'(val[15:0]);
			CFG_MAX_ITER:  cap_m = longint'(val[9:0]);
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_regs(input longint bx, input longint by, input longint th,
		input longint cap);
		write_reg(CFG_BASE_X, bx);
		write_reg(CFG_BASE_Y, by);
		write_reg(CFG_THRESHOLD, th);
		write_reg(CFG_MAX_ITER, cap);
	endtask

	// mostly reachable targets and sane joints, some raw noise; tiny keeps the
	// chain short so solves converge at once
	task automatic add_random(input int n, input bit tiny);
		int r, lo, hi, ang, blen, span;
		longint tx, ty;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			span = tiny ? 16384 : 60000;
			tx = base_xm + $signed($urandom_range(0, 2 * span)) - span;
			ty = base_ym + $signed($urandom_range(0, 2 * span)) - span;
			if (!tiny && $urandom_range(0, 9) < 2) begin
				tx = $signed($urandom() & 20'hFFFFF) - (($urandom() & 1) ? 0 : 0);
				tx = longint'($signed(tx[19:0]));
				ty = longint'($signed(20'($urandom())));
			end
			lo = -$signed($urandom_range(0, 25736));
			hi = $urandom_range(0, 25736);
			ang = $signed($urandom_range(0, hi - lo)) + lo;
			if ($urandom_range(0, 9) == 0) begin
				lo = $signed($urandom_range(0, 51472)) - 25736;
				hi = $signed($urandom_range(0, 51472)) - 25736;
				ang = $signed($urandom_range(0, 51472)) - 25736;
			end
			if (tiny) blen = $urandom_range(0, 4096);
			else if ($urandom_range(0, 9) < 2) blen = $urandom_range(0, 262143);
			else blen = $urandom_range(256, 15360);
			if (r < 50) add_word(F_LOAD, $urandom_range(0, 7), blen, lo, hi, ang, tx, ty);
			else if (r < 83) add_word(F_ITER, $urandom(), $urandom(), $urandom(),
				$urandom(), $urandom(), tx, ty);
			else if (r < 95) add_word(F_SOLVE, $urandom(), $urandom(), $urandom(),
				$urandom(), $urandom(), tx, ty);
			else add_word(F_UNUSED, $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom(), tx, ty);
		end
	endtask

	initial begin
		base_xm = 0;
		base_ym = 0;
		thresh_m = 256;
		cap_m = 100;
		for (int i = 0; i < JOINTS; i++) begin
			ang_q13[i] = 0;
			len_q8[i] = 0;
			min_q13[i] = -25736;
			max_q13[i] = 25736;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// all bones zero: end and pivots coincide with the target
		add_word(F_ITER, 0, 0, 0, 0, 0, 0, 0);
		add_word(F_UNUSED, 7, 262143, -1, -1, -1, 524287, -524288);
		wait_idle();
		set_regs(0, 0, 256, 2);
		add_word(F_LOAD, 0, 262143, -25736, 25736, 25736, 0, 0);
		add_word(F_LOAD, 7, 0, 25736, -25736, -25736, 524287, 524287);
		add_word(F_ITER, 0, 0, 0, 0, 0, -524288, -524288);
		add_word(F_LOAD, 0, 2560, -25736, 25736, 0, 0, 0);
		for (int j = 1; j < 7; j++)
			add_word(F_LOAD, j, 5120, -12000, 12000, (j == 3) ? 20000 : 0, 0, 0);
		add_word(F_LOAD, 3, 5120, -100, 100, 2000, 0, 0);
		add_word(F_ITER, 0, 0, 0, 0, 0, 10000, -10000);
		add_word(F_ITER, 0, 0, 0, 0, 0, -524288, 524287);
		add_word(F_SOLVE, 0, 0, 0, 0, 0, 20000, 30000);
		add_word(F_UNUSED, 0, 0, 0, 0, 0, 0, 0);
		add_word(F_LOAD, 5, 7680, 3000, -3000, 0, -20000, 0);
		add_word(F_ITER, 0, 0, 0, 0, 0, -20000, 0);
		add_word(F_SOLVE, 0, 0, 0, 0, 0, 524287, 524287);
		wait_idle();

		for (int ph = 0; ph < 5; ph++) begin
			no_gaps = (ph % 2 == 1);
			case (ph)
				0: set_regs(524287, -524288, 65535, 1);
				1: set_regs(-524288, 524287, 0, 3);
				2: set_regs($signed(20'($urandom())) / 4, $signed(20'($urandom())) / 4,
					$urandom_range(0, 65535), 0);
				3: set_regs($signed(20'($urandom())) / 2, $signed(20'($urandom())) / 2,
					65535, 1023);
				default: set_regs($signed($urandom_range(0, 40000)) - 20000,
					$signed($urandom_range(0, 40000)) - 20000, $urandom_range(0, 2048), 2);
			endcase
			if (ph == 3) begin
				for (int j = 0; j < JOINTS; j++)
					add_word(F_LOAD, j, 256, -25736, 25736, 0, base_xm, base_ym);
				add_word(F_SOLVE, 0, 0, 0, 0, 0, base_xm, base_ym);
			end
			add_random(80, ph == 3);
			wait_idle();
		end

		repeat (400) @(posedge clk);
		if (mismatches == 0 && pose_q.size() == 0) begin
			$display("PASS ccd_inverse_kinematics");
		end else begin
			$display("FAIL ccd_inverse_kinematics");
		end
		$finish;
	end
endmodule

// ===== ccd_inverse_kinematics.f =====
sv/ccd_pkg.sv
sv/ccd_cordic.sv
sv/ccd_dp.sv
sv/ccd_ctrl.sv
sv/ccd_inverse_kinematics.sv
sim/tb_top.sv
